>>> design/sdi_pkg.sv
// Shared types and constants for the SDI-12 bus master.
// Used by every module of the block; depends on nothing.
package sdi_pkg;

  // Line limits and store size.
  localparam int unsigned IdentLineBytes  = 40;
  localparam int unsigned DataLineBytes   = 100;
  localparam int unsigned ShortLineBytes  = 8;
  localparam int unsigned MaxDataRequests = 10;
  localparam int unsigned StoreDepth      = 40;
  localparam int unsigned StoreAw         = $clog2(StoreDepth);
  localparam int unsigned QDepth          = 2;
  localparam int unsigned QAw             = $clog2(QDepth);

  // Reply checks.
  localparam int unsigned IdentMinLen  = 20;
  localparam int unsigned IdentMaxLen  = 34;
  localparam int unsigned MReplyMinLen = 5;
  localparam int unsigned CountMax     = 999;
  localparam int unsigned TicksPerSec  = 1000;
  localparam int unsigned TimeoutReset = 1000;

  // Action codes at the input.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Command codes.
  localparam logic [2:0] CMD_ACK     = 3'd0;
  localparam logic [2:0] CMD_QUERY   = 3'd1;
  localparam logic [2:0] CMD_IDENT   = 3'd2;
  localparam logic [2:0] CMD_CHANGE  = 3'd3;
  localparam logic [2:0] CMD_MEASURE = 3'd4;

  // Characters.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_C  = 8'h43;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_I  = 8'h49;
  localparam logic [7:0] CH_UP_M  = 8'h4D;

  typedef enum logic [1:0] {
    CLS_START,
    CLS_BYTE,
    CLS_TICK
  } cls_e;

  typedef enum logic [2:0] {
    KIND_TX,
    KIND_IDENT,
    KIND_SIGN,
    KIND_DIGIT,
    KIND_DONE
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TIMEOUT,
    ST_INVALID,
    ST_OVERFLOW,
    ST_UNSUPPORTED
  } status_e;

  typedef struct packed {
    cls_e       cls;
    logic [2:0] command;
    logic [3:0] address;
    logic [3:0] arg;
    logic       concurrent;
    logic       want_crc;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
    logic [9:0] value_index;
    status_e    status;
    logic [3:0] found_address;
    logic [9:0] value_count;
    logic       last;
  } res_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

>>> design/sdi_front.sv
// Front end: accepts input requests, classifies the action and queues them.
// Depends on sdi_pkg.
module sdi_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [1:0]    action_i,
  input  logic [2:0]    command_i,
  input  logic [3:0]    address_i,
  input  logic [3:0]    arg_i,
  input  logic          concurrent_i,
  input  logic          want_crc_i,
  input  logic [7:0]    rx_byte_i,
  output sdi_pkg::item_t item_o,
  output logic          item_valid_o,
  input  logic          item_pop_i
);
  import sdi_pkg::*;

  item_t          q_mem [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAw:0]   cnt_q;
  logic           store;
  logic           take;
  item_t          item_in;

  assign full_o       = (cnt_q == (QAw+1)'(QDepth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_mem[rd_ptr_q];

  // Unknown actions are taken from the bus but never reach the back end.
  assign store = push_i && !full_o &&
                 (action_i == ACT_START || action_i == ACT_BYTE || action_i == ACT_TICK);
  assign take  = item_pop_i && item_valid_o;

  always_comb begin
    item_in.cls        = CLS_TICK;
    item_in.command    = command_i;
    item_in.address    = address_i;
    item_in.arg        = arg_i;
    item_in.concurrent = concurrent_i;
    item_in.want_crc   = want_crc_i;
    item_in.rx_byte    = rx_byte_i;
    if (action_i == ACT_START) begin
      item_in.cls = CLS_START;
    end else if (action_i == ACT_BYTE) begin
      item_in.cls = CLS_BYTE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      q_mem[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (store) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (take) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (store && !take) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (take && !store) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> design/sdi_back.sv
// Back end: transaction sequencer with the line store and result emission.
// Depends on sdi_pkg.
module sdi_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  sdi_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_pop_o,
  output sdi_pkg::res_t  res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);
  import sdi_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ACK, PH_QUERY, PH_IDENT, PH_CHANGE, PH_MREPLY, PH_SERVICE, PH_DATA
  } phase_e;

  typedef enum logic [3:0] {
    S_FETCH, S_CNT_RD, S_CNT_USE, S_MSETUP, S_PRE, S_ID_RD, S_ID_EMIT, S_TX, S_DONE
  } seq_e;

  seq_e   seq_q, seq_d;
  phase_e phase_q, phase_d;
  logic [15:0]      timeout_q, timeout_d;
  logic [6:0]       line_len_q, line_len_d;
  logic [7:0]       prev_q, prev_d;
  logic [19:0]      timer_q, timer_d;
  logic [3:0]       target_q, target_d;
  logic [9:0]       expected_q, expected_d;
  logic [9:0]       seen_q, seen_d;
  logic [3:0]       req_q, req_d;
  logic [2:0][7:0]  crc_q, crc_d;
  logic [1:0]       mode_q, mode_d;
  logic [3:0][7:0]  head_q, head_d;
  logic [9:0]       ttt_q, ttt_d;
  logic [9:0]       cnt_q, cnt_d;
  logic [5:0]       cnt_ptr_q, cnt_ptr_d;
  logic [5:0]       cnt_end_q, cnt_end_d;
  logic             pre_v_q, pre_v_d;
  kind_e            pre_kind_q, pre_kind_d;
  logic [7:0]       pre_byte_q, pre_byte_d;
  logic [9:0]       pre_idx_q, pre_idx_d;
  logic             id_v_q, id_v_d;
  logic [5:0]       id_ptr_q, id_ptr_d;
  logic [5:0]       id_last_q, id_last_d;
  logic [6:0][7:0]  txb_q, txb_d;
  logic [2:0]       tx_n_q, tx_n_d;
  logic             done_v_q, done_v_d;
  status_e          done_st_q, done_st_d;
  logic [3:0]       done_found_q, done_found_d;

  // Line store, one write and one registered read per cycle.
  logic [7:0]         store_mem [StoreDepth];
  logic [7:0]         rd_q;
  logic               mem_we, mem_re;
  logic [StoreAw-1:0] mem_wa, mem_ra;

  // Working signals of the dispatch logic.
  logic          do_finish, do_after, do_send, go_count, dispatched, emit_old;
  status_e       fin_st;
  logic [3:0]    fin_found;
  logic [7:0]    rb, achar, sa, old;
  logic [7:0]    p1, limit;
  logic [6:0]    p, ln;
  logic [9:0]    seen_n;
  logic [3:0]    req_inc;
  logic [19:0]   t;
  logic [13:0]   acc;
  logic [2:0]    k;

  function automatic seq_e next_emit(logic pre, logic idv, logic [2:0] n, logic dv);
    seq_e s;
    if (pre) begin
      s = S_PRE;
    end else if (idv) begin
      s = S_ID_RD;
    end else if (n != 3'd0) begin
      s = S_TX;
    end else if (dv) begin
      s = S_DONE;
    end else begin
      s = S_FETCH;
    end
    return s;
  endfunction

  always_comb begin
    seq_d = seq_q;           phase_d = phase_q;       timeout_d = timeout_q;
    line_len_d = line_len_q; prev_d = prev_q;         timer_d = timer_q;
    target_d = target_q;     expected_d = expected_q; seen_d = seen_q;
    req_d = req_q;           crc_d = crc_q;           mode_d = mode_q;
    head_d = head_q;         ttt_d = ttt_q;           cnt_d = cnt_q;
    cnt_ptr_d = cnt_ptr_q;   cnt_end_d = cnt_end_q;
    pre_v_d = pre_v_q;       pre_kind_d = pre_kind_q; pre_byte_d = pre_byte_q;
    pre_idx_d = pre_idx_q;   id_v_d = id_v_q;         id_ptr_d = id_ptr_q;
    id_last_d = id_last_q;   txb_d = txb_q;           tx_n_d = tx_n_q;
    done_v_d = done_v_q;     done_st_d = done_st_q;   done_found_d = done_found_q;

    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = line_len_q[StoreAw-1:0];
    mem_ra     = id_ptr_q[StoreAw-1:0];

    do_finish  = 1'b0;
    do_after   = 1'b0;
    do_send    = 1'b0;
    go_count   = 1'b0;
    dispatched = 1'b0;
    emit_old   = 1'b0;
    fin_st     = ST_OK;
    fin_found  = '0;
    rb         = item_i.rx_byte;
    achar      = CH_ZERO + {4'b0, target_q};
    sa         = CH_ZERO + {4'b0, item_i.address};
    old        = prev_q;
    p          = line_len_q;
    p1         = {1'b0, line_len_q} + 8'd1;
    ln         = line_len_q - 7'd1;
    limit      = 8'(DataLineBytes);
    seen_n     = seen_q;
    req_inc    = req_q + 4'd1;
    t          = timer_q;
    acc        = 14'(cnt_q) * 14'd10 + 14'(rd_q[3:0]);
    k          = '0;

    if (cfg_we_i) begin
      timeout_d = cfg_wdata_i;
    end

    unique case (seq_q)
      S_FETCH: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          dispatched = 1'b1;
          pre_v_d    = 1'b0;
          id_v_d     = 1'b0;
          tx_n_d     = '0;
          done_v_d   = 1'b0;
          unique case (item_i.cls)
            CLS_START: begin
              if (phase_q == PH_IDLE) begin
                expected_d = '0;
                seen_d     = '0;
                req_d      = '0;
                line_len_d = '0;
                prev_d     = '0;
                timer_d    = '0;
                crc_d      = '0;
                mode_d     = {item_i.want_crc, item_i.concurrent};
                target_d   = item_i.address;
                unique case (item_i.command)
                  CMD_ACK: begin
                    txb_d[0] = sa;
                    k        = 3'd1;
                    phase_d  = PH_ACK;
                  end
                  CMD_QUERY: begin
                    txb_d[0] = CH_QMARK;
                    k        = 3'd1;
                    phase_d  = PH_QUERY;
                  end
                  CMD_IDENT: begin
                    txb_d[0] = sa;
                    txb_d[1] = CH_UP_I;
                    k        = 3'd2;
                    phase_d  = PH_IDENT;
                  end
                  CMD_CHANGE: begin
                    txb_d[0] = sa;
                    txb_d[1] = CH_UP_A;
                    txb_d[2] = CH_ZERO + {4'b0, item_i.arg};
                    k        = 3'd3;
                    target_d = item_i.arg;
                    phase_d  = PH_CHANGE;
                  end
                  CMD_MEASURE: begin
                    txb_d[0] = sa;
                    txb_d[1] = item_i.concurrent ? CH_UP_C : CH_UP_M;
                    k        = 3'd2;
                    if (item_i.want_crc) begin
                      txb_d[k] = CH_UP_C;
                      k        = k + 3'd1;
                    end
                    if (item_i.arg != 4'd0) begin
                      txb_d[k] = CH_ZERO + {4'b0, item_i.arg};
                      k        = k + 3'd1;
                    end
                    phase_d = PH_MREPLY;
                  end
                  default: begin
                    do_finish = 1'b1;
                    fin_st    = ST_UNSUPPORTED;
                  end
                endcase
                if (!do_finish) begin
                  txb_d[k]        = CH_BANG;
                  txb_d[k + 3'd1] = CH_CR;
                  txb_d[k + 3'd2] = CH_LF;
                  tx_n_d          = k + 3'd3;
                end
              end
            end
            CLS_BYTE: begin
              if (phase_q == PH_DATA) begin
                timer_d = '0;
                if (p == 7'd0) begin
                  if (rb != achar) begin
                    do_finish = 1'b1;
                    fin_st    = ST_INVALID;
                  end else begin
                    prev_d     = rb;
                    line_len_d = 7'd1;
                  end
                end else if (rb == CH_LF && prev_q == CH_CR) begin
                  if (seen_q >= expected_q) begin
                    do_finish = 1'b1;
                    fin_st    = ST_OK;
                  end else begin
                    req_d = req_inc;
                    if (req_inc >= 4'(MaxDataRequests)) begin
                      do_finish = 1'b1;
                      fin_st    = ST_INVALID;
                    end else begin
                      do_send = 1'b1;
                    end
                  end
                end else begin
                  // With CRC the last three characters trail in a small delay line.
                  if (mode_q[1]) begin
                    old      = crc_q[0];
                    crc_d[0] = crc_q[1];
                    crc_d[1] = crc_q[2];
                    crc_d[2] = prev_q;
                    emit_old = (p >= 7'd5);
                  end else begin
                    old      = prev_q;
                    emit_old = (p >= 7'd2);
                  end
                  prev_d = rb;
                  if (emit_old) begin
                    if (old == CH_PLUS || old == CH_MINUS) begin
                      seen_n = (seen_q != '1) ? seen_q + 10'd1 : seen_q;
                      seen_d = seen_n;
                      if (seen_n <= expected_q) begin
                        pre_v_d    = 1'b1;
                        pre_kind_d = KIND_SIGN;
                        pre_byte_d = old;
                        pre_idx_d  = seen_n - 10'd1;
                      end
                    end else if (seen_q != '0 && seen_q <= expected_q) begin
                      pre_v_d    = 1'b1;
                      pre_kind_d = KIND_DIGIT;
                      pre_byte_d = old;
                      pre_idx_d  = seen_q - 10'd1;
                    end
                  end
                  if (p1 >= 8'(DataLineBytes)) begin
                    do_finish = 1'b1;
                    fin_st    = ST_OVERFLOW;
                  end else begin
                    line_len_d = p1[6:0];
                  end
                end
              end else if (phase_q != PH_IDLE) begin
                if (phase_q == PH_ACK || phase_q == PH_QUERY || phase_q == PH_CHANGE) begin
                  limit = 8'(ShortLineBytes);
                end else if (phase_q == PH_IDENT) begin
                  limit = 8'(IdentLineBytes);
                end
                if (phase_q != PH_SERVICE) begin
                  timer_d = '0;
                end
                if (p < 7'(StoreDepth)) begin
                  mem_we = 1'b1;
                end
                if (p < 7'd4) begin
                  head_d[p[1:0]] = rb;
                end
                if (rb == CH_LF && p != 7'd0 && prev_q == CH_CR) begin
                  unique case (phase_q)
                    PH_ACK, PH_CHANGE: begin
                      do_finish = 1'b1;
                      fin_st    = (ln == 7'd1 && head_q[0] == achar) ? ST_OK : ST_INVALID;
                    end
                    PH_QUERY: begin
                      do_finish = 1'b1;
                      if (ln == 7'd1 && is_digit(head_q[0])) begin
                        fin_st    = ST_OK;
                        fin_found = head_q[0][3:0];
                      end else begin
                        fin_st = ST_INVALID;
                      end
                    end
                    PH_IDENT: begin
                      do_finish = 1'b1;
                      if (ln >= 7'(IdentMinLen) && ln < 7'(IdentMaxLen) &&
                          head_q[0] == achar) begin
                        fin_st    = ST_OK;
                        id_v_d    = 1'b1;
                        id_ptr_d  = 6'd1;
                        id_last_d = ln[5:0] - 6'd1;
                      end else begin
                        fin_st = ST_INVALID;
                      end
                    end
                    PH_MREPLY: begin
                      if (ln < 7'(MReplyMinLen) || head_q[0] != achar ||
                          !is_digit(head_q[1]) || !is_digit(head_q[2]) ||
                          !is_digit(head_q[3])) begin
                        do_finish = 1'b1;
                        fin_st    = ST_INVALID;
                      end else begin
                        ttt_d     = 10'(head_q[1][3:0]) * 10'd100 +
                                    10'(head_q[2][3:0]) * 10'd10 + 10'(head_q[3][3:0]);
                        cnt_d     = '0;
                        cnt_ptr_d = 6'd4;
                        cnt_end_d = (ln < 7'(StoreDepth)) ? ln[5:0] : 6'(StoreDepth);
                        go_count  = 1'b1;
                      end
                    end
                    default: begin
                      do_after = 1'b1;
                    end
                  endcase
                end else begin
                  prev_d = rb;
                  if (p1 >= limit) begin
                    if (phase_q == PH_SERVICE) begin
                      do_after = 1'b1;
                    end else begin
                      do_finish = 1'b1;
                      fin_st    = ST_OVERFLOW;
                    end
                  end else begin
                    line_len_d = p1[6:0];
                  end
                end
              end
            end
            CLS_TICK: begin
              if (phase_q == PH_SERVICE) begin
                t       = (timer_q != '0) ? timer_q - 20'd1 : timer_q;
                timer_d = t;
                if (t == '0) begin
                  do_after = 1'b1;
                end
              end else if (phase_q != PH_IDLE) begin
                t       = (timer_q != '1) ? timer_q + 20'd1 : timer_q;
                timer_d = t;
                if (t >= {4'b0, timeout_q}) begin
                  do_finish = 1'b1;
                  fin_st    = ST_TIMEOUT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_CNT_RD: begin
        if (cnt_ptr_q < cnt_end_q) begin
          mem_re = 1'b1;
          mem_ra = cnt_ptr_q[StoreAw-1:0];
          seq_d  = S_CNT_USE;
        end else begin
          seq_d = S_MSETUP;
        end
      end
      S_CNT_USE: begin
        if (is_digit(rd_q)) begin
          cnt_d     = (acc > 14'(CountMax)) ? 10'(CountMax) : acc[9:0];
          cnt_ptr_d = cnt_ptr_q + 6'd1;
          seq_d     = S_CNT_RD;
        end else begin
          seq_d = S_MSETUP;
        end
      end
      S_MSETUP: begin
        dispatched = 1'b1;
        expected_d = cnt_q;
        seen_d     = '0;
        req_d      = '0;
        if (ttt_q == '0) begin
          do_after = 1'b1;
        end else begin
          line_len_d = '0;
          prev_d     = '0;
          crc_d      = '0;
          timer_d    = 20'(ttt_q) * 20'(TicksPerSec);
          phase_d    = PH_SERVICE;
        end
      end
      S_PRE: begin
        if (!res_full_i) begin
          res_push_o        = 1'b1;
          res_o.kind        = pre_kind_q;
          res_o.byte_value  = pre_byte_q;
          res_o.value_index = pre_idx_q;
          res_o.last        = !id_v_q && tx_n_q == '0 && !done_v_q;
          pre_v_d           = 1'b0;
          seq_d             = next_emit(1'b0, id_v_q, tx_n_q, done_v_q);
        end
      end
      S_ID_RD: begin
        mem_re = 1'b1;
        seq_d  = S_ID_EMIT;
      end
      S_ID_EMIT: begin
        if (!res_full_i) begin
          res_push_o       = 1'b1;
          res_o.kind       = KIND_IDENT;
          res_o.byte_value = rd_q;
          res_o.last       = (id_ptr_q == id_last_q) && tx_n_q == '0 && !done_v_q;
          if (id_ptr_q == id_last_q) begin
            id_v_d = 1'b0;
            seq_d  = next_emit(1'b0, 1'b0, tx_n_q, done_v_q);
          end else begin
            id_ptr_d = id_ptr_q + 6'd1;
            seq_d    = S_ID_RD;
          end
        end
      end
      S_TX: begin
        if (!res_full_i) begin
          res_push_o       = 1'b1;
          res_o.kind       = KIND_TX;
          res_o.byte_value = txb_q[0];
          res_o.last       = (tx_n_q == 3'd1) && !done_v_q;
          for (int i = 0; i < 6; i++) begin
            txb_d[i] = txb_q[i+1];
          end
          tx_n_d = tx_n_q - 3'd1;
          if (tx_n_q == 3'd1) begin
            seq_d = next_emit(1'b0, 1'b0, 3'd0, done_v_q);
          end
        end
      end
      S_DONE: begin
        if (!res_full_i) begin
          res_push_o          = 1'b1;
          res_o.kind          = KIND_DONE;
          res_o.status        = done_st_q;
          res_o.found_address = done_found_q;
          res_o.value_count   = expected_q;
          res_o.last          = 1'b1;
          done_v_d            = 1'b0;
          seq_d               = S_FETCH;
        end
      end
      default: begin
        seq_d = S_FETCH;
      end
    endcase

    // Service wait over, or no wait at all (ttt is zero): either finish or send the first data request.
    if (do_after) begin
      if (expected_d == '0) begin
        do_finish = 1'b1;
        fin_st    = ST_OK;
      end else begin
        do_send = 1'b1;
      end
    end
    if (do_send) begin
      txb_d[0]   = CH_ZERO + {4'b0, target_d};
      txb_d[1]   = CH_UP_D;
      txb_d[2]   = CH_ZERO + {4'b0, req_d};
      txb_d[3]   = CH_BANG;
      txb_d[4]   = CH_CR;
      txb_d[5]   = CH_LF;
      tx_n_d     = 3'd6;
      line_len_d = '0;
      prev_d     = '0;
      timer_d    = '0;
      crc_d      = '0;
      phase_d    = PH_DATA;
    end
    if (do_finish) begin
      done_v_d     = 1'b1;
      done_st_d    = fin_st;
      done_found_d = fin_found;
      phase_d      = PH_IDLE;
    end
    if (dispatched) begin
      seq_d = go_count ? S_CNT_RD : next_emit(pre_v_d, id_v_d, tx_n_d, done_v_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_wa] <= rb;
    end
    if (mem_re) begin
      rd_q <= store_mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= S_FETCH;       phase_q <= PH_IDLE;     timeout_q <= 16'(TimeoutReset);
      line_len_q <= '0;       prev_q <= '0;           timer_q <= '0;
      target_q <= '0;         expected_q <= '0;       seen_q <= '0;
      req_q <= '0;            crc_q <= '0;            mode_q <= '0;
      head_q <= '0;           ttt_q <= '0;            cnt_q <= '0;
      cnt_ptr_q <= '0;        cnt_end_q <= '0;
      pre_v_q <= 1'b0;        pre_kind_q <= KIND_TX;  pre_byte_q <= '0;
      pre_idx_q <= '0;        id_v_q <= 1'b0;         id_ptr_q <= '0;
      id_last_q <= '0;        txb_q <= '0;            tx_n_q <= '0;
      done_v_q <= 1'b0;       done_st_q <= ST_OK;     done_found_q <= '0;
    end else begin
      seq_q <= seq_d;         phase_q <= phase_d;     timeout_q <= timeout_d;
      line_len_q <= line_len_d; prev_q <= prev_d;     timer_q <= timer_d;
      target_q <= target_d;   expected_q <= expected_d; seen_q <= seen_d;
      req_q <= req_d;         crc_q <= crc_d;         mode_q <= mode_d;
      head_q <= head_d;       ttt_q <= ttt_d;         cnt_q <= cnt_d;
      cnt_ptr_q <= cnt_ptr_d; cnt_end_q <= cnt_end_d;
      pre_v_q <= pre_v_d;     pre_kind_q <= pre_kind_d; pre_byte_q <= pre_byte_d;
      pre_idx_q <= pre_idx_d; id_v_q <= id_v_d;       id_ptr_q <= id_ptr_d;
      id_last_q <= id_last_d; txb_q <= txb_d;         tx_n_q <= tx_n_d;
      done_v_q <= done_v_d;   done_st_q <= done_st_d; done_found_q <= done_found_d;
    end
  end

endmodule

>>> design/sdi_outq.sv
// Result queue between the sequencer and the result port.
// Depends on sdi_pkg.
module sdi_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sdi_pkg::res_t res_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sdi_pkg::res_t res_o
);
  import sdi_pkg::*;

  res_t           q_mem [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAw:0]   cnt_q;
  logic           store, take;

  assign full_o  = (cnt_q == (QAw+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign res_o   = q_mem[rd_ptr_q];
  assign store   = push_i && !full_o;
  assign take    = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (store) begin
      q_mem[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (store) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (take) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (store && !take) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (take && !store) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> design/sdi12_master_transaction.sv
// Top level of the SDI-12 bus master: front end, sequencer and result queue.
// Depends on sdi_pkg, sdi_front, sdi_back and sdi_outq.
//
//   Channel   Handshake          Payload
//   -------   ----------------   ----------------------------------------------
//   request   push / full        action, command, address, arg, concurrent,
//                                want_crc, rx_byte
//   result    empty / pop        kind, byte_value, value_index, status,
//                                found_address, value_count, last
//   config    cfg_we_i           cfg_wdata_i = reply_timeout_ms
//
// A request is queued in a two-entry queue and dispatched by the sequencer,
// which pushes each result into the result queue; each identification byte is
// first read from the line store, and a measure reply reads each count digit
// that it parses back from the line store.
// A stalled result port stalls only the sequencer; requests keep queuing until
// the front queue is full. Reset clears all control state; the line store is
// not cleared and holds only bytes of the current line when it is read.
module sdi12_master_transaction (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [2:0]  command_i,
  input  logic [3:0]  address_i,
  input  logic [3:0]  arg_i,
  input  logic        concurrent_i,
  input  logic        want_crc_i,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [9:0]  value_index_o,
  output logic [2:0]  status_o,
  output logic [3:0]  found_address_o,
  output logic [9:0]  value_count_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import sdi_pkg::*;

  item_t item;
  logic  item_valid, item_pop;
  res_t  res_new, res_head;
  logic  res_push, res_full;

  // The front end only queues and classifies; all protocol state lives behind it.
  sdi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .action_i     (action_i),
    .command_i    (command_i),
    .address_i    (address_i),
    .arg_i        (arg_i),
    .concurrent_i (concurrent_i),
    .want_crc_i   (want_crc_i),
    .rx_byte_i    (rx_byte_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // The sequencer executes one request at a time and streams its results.
  sdi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .res_o        (res_new),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  // Results wait here so the sequencer can run ahead of the consumer.
  sdi_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_new),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_head)
  );

  assign kind_o          = res_head.kind;
  assign byte_value_o    = res_head.byte_value;
  assign value_index_o   = res_head.value_index;
  assign status_o        = res_head.status;
  assign found_address_o = res_head.found_address;
  assign value_count_o   = res_head.value_count;
  assign last_o          = res_head.last;

  // The sequencer must never offer a result the queue cannot hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(res_push && res_full))
    else $error("result pushed into a full result queue");

  // The sequencer must only take a request that is actually queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(item_pop && !item_valid))
    else $error("request taken from an empty front queue");

  // A result that ends a transaction is always the last one of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_push && res_new.kind == KIND_DONE) |-> res_new.last)
    else $error("done result not marked last");

endmodule
